FILE: design/page_frame_free_list_defines.svh
// Assertion macros for the page frame free list.
`ifndef PAGE_FRAME_FREE_LIST_DEFINES_SVH
`define PAGE_FRAME_FREE_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define PFFL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pffl implication check failed");
`define PFFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pffl next-cycle check failed");
`else
`define PFFL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PFFL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/pffl_pkg.sv
// Package with types, codes and defaults of the page frame free list.
`default_nettype none
package pffl_pkg;

   localparam int unsigned NUM_FRAMES_DEF  = 128;
   localparam int unsigned FRAME_BYTES_DEF = 2097152;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] frame_count;
      logic [6:0] run_head;
      logic       run_given;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [6:0]  first_frame;
      logic [27:0] first_address;
      logic        pool_empty;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tbl_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } walk_state_type;

endpackage
`default_nettype wire

FILE: design/pffl_link_table.sv
// Next-link table: one read and one write port, per-entry valid bits.
`default_nettype none
module pffl_link_table import pffl_pkg::*; #(
   parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tbl_ctl_type                       ctl,
   input  wire logic [$clog2(NUM_FRAMES)-1:0]     rd_addr,
   input  wire logic [$clog2(NUM_FRAMES)-1:0]     wr_addr,
   input  wire logic [$clog2(NUM_FRAMES+1)-1:0]   wr_data,
   output logic      [$clog2(NUM_FRAMES+1)-1:0]   rd_link
);

   localparam int unsigned IW = $clog2(NUM_FRAMES);
   localparam int unsigned LW = $clog2(NUM_FRAMES + 1);

   logic [LW-1:0]         link_mem_ff [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] valid_ff;
   logic [LW-1:0]         rd_data_ff;
   logic                  rd_vld_ff;
   logic [IW-1:0]         rd_addr_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         link_mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= link_mem_ff[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // unwritten entry i links to i+1; the last one lands on the null code
   assign rd_link = rd_vld_ff ? rd_data_ff : (LW'(rd_addr_ff) + LW'(1));

endmodule
`default_nettype wire

FILE: design/pffl_walker.sv
// Sequencer that walks the link table for allocate and free requests.
`default_nettype none
module pffl_walker import pffl_pkg::*; #(
   parameter int unsigned NUM_FRAMES  = NUM_FRAMES_DEF,
   parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire req_type                           req,
   input  wire logic [$clog2(NUM_FRAMES+1)-1:0]   link_data,
   input  wire logic                              rsp_take,
   output logic                                   idle,
   output tbl_ctl_type                            tbl_ctl,
   output logic      [$clog2(NUM_FRAMES)-1:0]     rd_addr,
   output logic      [$clog2(NUM_FRAMES)-1:0]     wr_addr,
   output logic      [$clog2(NUM_FRAMES+1)-1:0]   wr_data,
   output logic                                   rsp_valid,
   output rsp_type                                rsp
);

   localparam int unsigned IW = $clog2(NUM_FRAMES);
   localparam int unsigned LW = $clog2(NUM_FRAMES + 1);
   localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
   localparam int unsigned PW = IW + 31;
   localparam logic [LW-1:0] NIL = LW'(NUM_FRAMES);
   localparam logic [31:0] NF32 = 32'(NUM_FRAMES);

   walk_state_type state_ff, state_in;
   logic           cmd_ff, cmd_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [IW-1:0]  cur_ff, cur_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [LW-1:0]  free_head_ff, free_head_in;
   rsp_type        rsp_ff, rsp_in;

   logic           alloc_ok;
   logic           free_ok;
   logic           walk_end;
   logic [PW-1:0]  addr_prod;

   assign alloc_ok = (req.frame_count != 8'd0) && (32'(req.frame_count) <= NF32)
                     && (free_head_ff != NIL);
   assign free_ok  = req.run_given && (32'(req.run_head) < NF32);
   assign addr_prod = PW'(free_head_ff[IW-1:0]) * PW'(FRAME_BYTES);

   // a walk ends on the last link of the run, a null link, or the step limit
   always_comb begin
      if (cmd_ff == CMD_ALLOC) begin
         walk_end = (cnt_ff == '0) || (link_data == NIL);
      end else begin
         walk_end = (link_data == NIL) || (cnt_ff == CW'(NUM_FRAMES));
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if ((req.command == CMD_ALLOC) ? alloc_ok : free_ok) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WALK: begin
            if (walk_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in       = cmd_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      free_head_in = free_head_ff;
      rsp_in       = rsp_ff;
      tbl_ctl      = '0;
      rd_addr      = cur_ff;
      wr_addr      = cur_ff;
      wr_data      = NIL;
      idle         = 1'b0;
      rsp_valid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            rsp_in.success       = 1'b0;
            rsp_in.first_frame   = '0;
            rsp_in.first_address = '0;
            rsp_in.pool_empty    = (free_head_ff == NIL);
            if (start) begin
               cmd_in  = req.command;
               head_in = IW'(req.run_head);
               if (req.command == CMD_ALLOC) begin
                  rd_addr = free_head_ff[IW-1:0];
                  cnt_in  = CW'(req.frame_count - 8'd1);
                  tbl_ctl.rd_en = alloc_ok;
               end else begin
                  rd_addr = IW'(req.run_head);
                  cnt_in  = '0;
                  tbl_ctl.rd_en = free_ok;
               end
               cur_in = rd_addr;
            end
         end
         ST_WALK: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (cnt_ff == '0) begin
                  // detach the run and hand out its first frame
                  tbl_ctl.wr_en        = 1'b1;
                  wr_data              = NIL;
                  free_head_in         = link_data;
                  rsp_in.success       = 1'b1;
                  rsp_in.first_frame   = 7'(free_head_ff[IW-1:0]);
                  rsp_in.first_address = addr_prod[27:0];
                  rsp_in.pool_empty    = (link_data == NIL);
               end else if (link_data != NIL) begin
                  tbl_ctl.rd_en = 1'b1;
                  rd_addr       = link_data[IW-1:0];
                  cur_in        = link_data[IW-1:0];
                  cnt_in        = cnt_ff - CW'(1);
               end
            end else begin
               if (link_data == NIL) begin
                  // splice the run in front of the free list
                  tbl_ctl.wr_en     = 1'b1;
                  wr_data           = free_head_ff;
                  free_head_in      = LW'(head_ff);
                  rsp_in.success    = 1'b1;
                  rsp_in.pool_empty = 1'b0;
               end else if (cnt_ff != CW'(NUM_FRAMES)) begin
                  tbl_ctl.rd_en = 1'b1;
                  rd_addr       = link_data[IW-1:0];
                  cur_in        = link_data[IW-1:0];
                  cnt_in        = cnt_ff + CW'(1);
               end
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      head_ff <= head_in;
      cur_ff  <= cur_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule
`default_nettype wire

FILE: design/page_frame_free_list.sv
// Top level of the page frame free list allocator.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_data (req_type)
//   rsp_      out        rsp_valid / rsp_stall  rsp_data (rsp_type)
//
// An allocate of n frames reads n links, a free reads one link per frame of its run,
// one link per cycle through the single read port of the link table.
// A looped run stops after NUM_FRAMES + 1 reads.
// A request holds req_stall through its reads and its done state,
// and longer while a finished result waits on rsp_stall.
// Requests rejected at once skip the walk and hold req_stall only in the done state.
// Reset restores the frame chain at once through per-entry valid bits.
// A stalled result waits in the output register while the next request walks.
`default_nettype none
`include "page_frame_free_list_defines.svh"
module page_frame_free_list import pffl_pkg::*; #(
   parameter int unsigned NUM_FRAMES  = NUM_FRAMES_DEF,
   parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int unsigned IW = $clog2(NUM_FRAMES);
   localparam int unsigned LW = $clog2(NUM_FRAMES + 1);

   tbl_ctl_type   tbl_ctl;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic [LW-1:0] wr_data;
   logic [LW-1:0] rd_link;
   logic          walk_idle;
   logic          walk_rsp_valid;
   rsp_type       walk_rsp;
   logic          start;
   logic          rsp_take;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff;

   assign req_stall = !walk_idle;
   assign start     = req_valid && !req_stall;
   assign rsp_take  = walk_rsp_valid && (!rsp_valid_ff || !rsp_stall);

   pffl_link_table #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_link (rd_link)
   );

   pffl_walker #(
      .NUM_FRAMES  (NUM_FRAMES),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .link_data (rd_link),
      .rsp_take  (rsp_take),
      .idle      (walk_idle),
      .tbl_ctl   (tbl_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rsp_valid (walk_rsp_valid),
      .rsp       (walk_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         rsp_data_ff <= walk_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PFFL_ASSERT_NEXT(a_busy_after_transfer, clock, reset, start, req_stall)
   `PFFL_ASSERT_IMPL(a_fail_zero_frame, clock, reset, rsp_valid && !rsp_data.success,
      (rsp_data.first_frame == '0) && (rsp_data.first_address == '0))
   `PFFL_ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   `PFFL_ASSERT_IMPL(a_take_when_done, clock, reset, rsp_take, req_stall)

endmodule
`default_nettype wire
